// ----- rtl/core/chr_pkg.sv -----
package chr_pkg;

  // splitmix64 finalizer constants
  localparam logic [63:0] GOLDEN_INCR = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
  localparam int unsigned SHIFT_A     = 30;
  localparam int unsigned SHIFT_B     = 27;
  localparam int unsigned SHIFT_C     = 31;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SPAN_W = VAL_W + 1;
  localparam int unsigned STEPS  = WORD_W;
  localparam int unsigned CNT_W  = $clog2(STEPS);

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_MOD = 1'b1
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_ctl_t;

endpackage

// ----- rtl/core/counter_hash_random_in_range.sv -----
// Counter-driven random integer in a signed inclusive range. Each request
// transaction carries lower and upper bounds; the block hashes (seed + counter)
// with the splitmix64 finalizer and returns lower + (hash mod span), where
// span = upper - lower + 1 is taken exactly in 33 bits. The counter advances by
// one for every request, including inverted bounds, which return the lower
// bound with out_tuser (range_error) set and skip the hash. One request is in
// flight at a time: in_tready is high only while the block is idle. A valid
// request passes from acceptance to out_tvalid through the setup state S_MIX,
// then three passes of 64 one-bit steps through the single shared shift-add
// unit (two 64-bit multiplies, one 64-by-33-bit remainder), each followed by a
// handoff. Inverted bounds answer in the cycle after acceptance. The seed
// register (reset 0) is written through the cfg channel, which is always
// ready; write it only while no request is outstanding.
module counter_hash_random_in_range (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] lower_bound, [63:32] upper_bound
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] random_value
  output logic        out_tuser,  // [0] range_error
  // seed write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data    // seed
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MIX  = 6'b000010,
    S_MUL1 = 6'b000100,
    S_MUL2 = 6'b001000,
    S_MOD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [chr_pkg::WORD_W-1:0]      seed_r, seed_nxt;
  logic [chr_pkg::WORD_W-1:0]      count_r, count_nxt;
  logic [chr_pkg::WORD_W-1:0]      base_r, base_nxt;
  logic [chr_pkg::VAL_W-1:0]       lower_r, lower_nxt;
  logic [chr_pkg::SPAN_W-1:0]      span_r, span_nxt;
  logic [chr_pkg::VAL_W-1:0]       value_r, value_nxt;
  logic                            err_r, err_nxt;

  logic                            in_fire;
  logic [chr_pkg::VAL_W-1:0]       in_lower;
  logic [chr_pkg::VAL_W-1:0]       in_upper;
  logic                            in_inverted;
  logic [chr_pkg::SPAN_W-1:0]      in_span;
  logic [chr_pkg::WORD_W-1:0]      mix_v;
  logic [chr_pkg::WORD_W-1:0]      hash;

  chr_pkg::unit_ctl_t              u_ctl;
  logic [chr_pkg::WORD_W-1:0]      u_a;
  logic [chr_pkg::WORD_W-1:0]      u_b;
  logic                            u_done;
  logic [chr_pkg::WORD_W-1:0]      u_result;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = value_r;
  assign out_tuser  = err_r;

  assign in_lower    = in_tdata[chr_pkg::VAL_W-1:0];
  assign in_upper    = in_tdata[2*chr_pkg::VAL_W-1:chr_pkg::VAL_W];
  assign in_inverted = ($signed(in_upper) < $signed(in_lower));
  // exact span in 33 bits: sign-extend both bounds, subtract, add one
  assign in_span = {in_upper[chr_pkg::VAL_W-1], in_upper}
                 - {in_lower[chr_pkg::VAL_W-1], in_lower}
                 + chr_pkg::SPAN_W'(1);

  // first mixer round before the first multiply
  always_comb begin
    mix_v = base_r + chr_pkg::GOLDEN_INCR;
    mix_v = mix_v ^ (mix_v >> chr_pkg::SHIFT_A);
  end

  assign hash = u_result ^ (u_result >> chr_pkg::SHIFT_C);

  always_comb begin
    state_nxt   = state_r;
    seed_nxt    = seed_r;
    count_nxt   = count_r;
    base_nxt    = base_r;
    lower_nxt   = lower_r;
    span_nxt    = span_r;
    value_nxt   = value_r;
    err_nxt     = err_r;
    u_ctl.start = 1'b0;
    u_ctl.op    = chr_pkg::OP_MUL;
    u_a         = mix_v;
    u_b         = chr_pkg::MIX_MUL_A;

    if (cfg_valid && cfg_ready) begin
      seed_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          base_nxt  = seed_r + count_r;
          count_nxt = count_r + chr_pkg::WORD_W'(1);
          lower_nxt = in_lower;
          span_nxt  = in_span;
          if (in_inverted) begin
            // skip the hash: answer with the lower bound and flag it
            value_nxt = in_lower;
            err_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = S_MIX;
          end
        end
      end
      S_MIX: begin
        u_ctl.start = 1'b1;
        u_ctl.op    = chr_pkg::OP_MUL;
        u_a         = mix_v;
        u_b         = chr_pkg::MIX_MUL_A;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        if (u_done) begin
          u_ctl.start = 1'b1;
          u_ctl.op    = chr_pkg::OP_MUL;
          u_a         = u_result ^ (u_result >> chr_pkg::SHIFT_B);
          u_b         = chr_pkg::MIX_MUL_B;
          state_nxt   = S_MUL2;
        end
      end
      S_MUL2: begin
        if (u_done) begin
          u_ctl.start = 1'b1;
          u_ctl.op    = chr_pkg::OP_MOD;
          u_a         = hash;
          u_b         = {{(chr_pkg::WORD_W-chr_pkg::SPAN_W){1'b0}}, span_r};
          state_nxt   = S_MOD;
        end
      end
      S_MOD: begin
        if (u_done) begin
          // remainder is below span, so its low 32 bits carry the offset
          value_nxt = lower_r + u_result[chr_pkg::VAL_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  chr_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (u_ctl),
    .opnd_a (u_a),
    .opnd_b (u_b),
    .done   (u_done),
    .result (u_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seed_r  <= '0;
      count_r <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seed_r  <= seed_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    lower_r <= lower_nxt;
    span_r  <= span_nxt;
    value_r <= value_nxt;
  end

`ifndef ASSERT_OFF
  // a new request never lands while a result still waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !out_tvalid)
    else $error("request accepted while result pending");

  // the counter advances by exactly one per accepted request
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (count_r == $past(count_r) + chr_pkg::WORD_W'(1)))
    else $error("sequence counter did not advance by one");

  // a flagged result always returns the lower bound
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == lower_r))
    else $error("range error result differs from lower bound");

  // the shared unit only finishes while the sequencer waits on it
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> (state_r == S_MUL1 || state_r == S_MUL2 || state_r == S_MOD))
    else $error("shared unit finished outside a wait state");
`endif

endmodule

// ----- rtl/core/chr_unit.sv -----
// Shared shift-add / shift-subtract unit: one bit per cycle.
// OP_MUL: result = (opnd_a * opnd_b) mod 2^64.
// OP_MOD: result = opnd_a mod opnd_b[32:0] (restoring division, remainder only).
module chr_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  chr_pkg::unit_ctl_t         ctl,
  input  logic [chr_pkg::WORD_W-1:0] opnd_a,
  input  logic [chr_pkg::WORD_W-1:0] opnd_b,
  output logic                       done,
  output logic [chr_pkg::WORD_W-1:0] result
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  chr_pkg::op_t                 op_r, op_nxt;
  logic [chr_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [chr_pkg::WORD_W-1:0]   acc_r, acc_nxt;
  logic [chr_pkg::WORD_W-1:0]   opnd_r, opnd_nxt;
  logic [chr_pkg::WORD_W-1:0]   mplier_r, mplier_nxt;

  logic [chr_pkg::SPAN_W:0]     trial;
  logic [chr_pkg::WORD_W-1:0]   add_a;
  logic [chr_pkg::WORD_W-1:0]   add_b;
  logic                         add_cin;
  logic [chr_pkg::WORD_W:0]     sum;
  logic                         last;

  // remainder shifted left with the next dividend bit
  assign trial = {acc_r[chr_pkg::SPAN_W-1:0], opnd_r[chr_pkg::WORD_W-1]};

  // the single adder: accumulate for multiply, trial subtract for modulo
  always_comb begin
    if (op_r == chr_pkg::OP_MUL) begin
      add_a   = acc_r;
      add_b   = opnd_r;
      add_cin = 1'b0;
    end else begin
      add_a   = {{(chr_pkg::WORD_W-chr_pkg::SPAN_W-1){1'b0}}, trial};
      add_b   = ~{{(chr_pkg::WORD_W-chr_pkg::SPAN_W){1'b0}},
                  mplier_r[chr_pkg::SPAN_W-1:0]};
      add_cin = 1'b1;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{chr_pkg::WORD_W{1'b0}}, add_cin};
  end

  assign last = (cnt_r == chr_pkg::CNT_W'(chr_pkg::STEPS - 1));

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    op_nxt     = op_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    opnd_nxt   = opnd_r;
    mplier_nxt = mplier_r;
    if (!busy_r) begin
      if (ctl.start) begin
        busy_nxt   = 1'b1;
        op_nxt     = ctl.op;
        cnt_nxt    = '0;
        acc_nxt    = '0;
        opnd_nxt   = opnd_a;
        mplier_nxt = opnd_b;
      end
    end else begin
      cnt_nxt  = cnt_r + chr_pkg::CNT_W'(1);
      opnd_nxt = opnd_r << 1;
      if (op_r == chr_pkg::OP_MUL) begin
        if (mplier_r[0]) begin
          acc_nxt = sum[chr_pkg::WORD_W-1:0];
        end
        mplier_nxt = mplier_r >> 1;
      end else begin
        // carry out set means no borrow: trial >= divisor
        if (sum[chr_pkg::WORD_W]) begin
          acc_nxt = sum[chr_pkg::WORD_W-1:0];
        end else begin
          acc_nxt = {{(chr_pkg::WORD_W-chr_pkg::SPAN_W-1){1'b0}}, trial};
        end
      end
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= chr_pkg::OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    opnd_r   <= opnd_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

// ----- tb/sv/counter_hash_random_in_range_checker.sv -----
module counter_hash_random_in_range_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [63:0] cfg_data,
  output int unsigned mismatch_count,
  output int unsigned pending_count,
  output int unsigned checked_count
);

  localparam logic [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MUL_1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MUL_2  = 64'h94D0_49BB_1331_11EB;

  typedef struct packed {
    logic [31:0] value;
    logic        range_err;
  } draw_t;

  draw_t       draws_due[$];
  logic [63:0] seed_q;
  logic [63:0] seq_q;

  function automatic logic [63:0] splitmix_finalize(input logic [63:0] x);
    logic [63:0] v;
    v = x + GOLDEN;
    v = (v ^ (v >> 30)) * MUL_1;
    v = (v ^ (v >> 27)) * MUL_2;
    return v ^ (v >> 31);
  endfunction

  // inverted bounds return lower with the error flag; otherwise lower + hash mod span
  function automatic draw_t draw_in_range(input logic signed [31:0] lo,
                                          input logic signed [31:0] hi,
                                          input logic [63:0] hash);
    draw_t       d;
    logic [32:0] span;
    logic [63:0] off;
    if (hi < lo) begin
      d.value     = lo;
      d.range_err = 1'b1;
    end else begin
      span        = {hi[31], hi} - {lo[31], lo} + 33'd1;
      off         = hash % {31'd0, span};
      d.value     = lo + off[31:0];
      d.range_err = 1'b0;
    end
    return d;
  endfunction

  always @(posedge clk) begin
    draw_t want;
    if (!rst_n) begin
      seed_q         = '0;
      seq_q          = '0;
      mismatch_count = 0;
      checked_count  = 0;
      draws_due.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        seed_q = cfg_data;
      if (in_tvalid && in_tready) begin
        draws_due.push_back(draw_in_range(in_tdata[31:0], in_tdata[63:32],
                                          splitmix_finalize(seq_q + seed_q)));
        seq_q = seq_q + 64'd1;
      end
      if (out_tvalid && out_tready) begin
        if (draws_due.size() == 0) begin
          $error("result with no request outstanding: random_value %0d range_error %0b",
                 $signed(out_tdata), out_tuser);
          mismatch_count++;
        end else begin
          want = draws_due.pop_front();
          checked_count++;
          if (out_tdata !== want.value) begin
            $error("random_value: expected %0d, got %0d",
                   $signed(want.value), $signed(out_tdata));
            mismatch_count++;
          end
          if (out_tuser !== want.range_err) begin
            $error("range_error: expected %0b, got %0b", want.range_err, out_tuser);
            mismatch_count++;
          end
        end
      end
    end
    pending_count = draws_due.size();
  end

endmodule

// ----- tb/sv/counter_hash_random_in_range_tb.sv -----
module counter_hash_random_in_range_tb;

  localparam int S32_MIN    = 32'sh8000_0000;
  localparam int S32_MAX    = 32'sh7FFF_FFFF;
  // hold the receiver well past the time a valid request takes
  localparam int LONG_HOLD  = 600;
  localparam int TAIL_WAIT  = 250;
  localparam int CYCLE_CAP  = 2_000_000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [31:0] lower_bound, [63:32] upper_bound
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] random_value
  logic        out_tuser;         // [0] range_error
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data   = '0;   // seed

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  // quiet and hold_reqs are shared between the stimulus and the receiver process
  bit          quiet      = 1'b0;
  int unsigned hold_reqs  = 0;
  int unsigned cycle_count = 0;
  int unsigned sent       = 0;
  int unsigned inverted   = 0;
  int unsigned seed_writes = 0;

  always #5 clk = ~clk;

  counter_hash_random_in_range dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  counter_hash_random_in_range_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatches),
    .pending_count (pending),
    .checked_count (checked)
  );

  // Offer one request and hold it until the block takes it. Skip the idle gap
  // in quiet stretches so back-to-back offers keep in_tvalid high throughout.
  task automatic send_request(input int lo, input int hi);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (hi < lo) inverted++;
  endtask

  // Drop the request, then wait out every outstanding result so the block is idle.
  task automatic drain_results(input int extra);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Write the seed only from an idle block.
  task automatic program_seed(input logic [63:0] value);
    drain_results(8);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    seed_writes++;
  endtask

  function automatic int corner_value(input int unsigned k);
    case (k)
      0:       return S32_MIN;
      1:       return -1;
      2:       return 0;
      default: return S32_MAX;
    endcase
  endfunction

  // Cover the field extremes, span of one, the full 2^32 span, spans just
  // past 2^31, and inverted bounds at the edges of the signed range.
  task automatic run_directed();
    int lo_list [20] = '{S32_MIN, S32_MIN, S32_MAX, 0, S32_MAX, 1, 0, S32_MIN + 1,
                         -1, 0, -5, S32_MIN, 0, S32_MIN, -1, S32_MIN, 100,
                         S32_MAX - 1, S32_MIN, 12345};
    int hi_list [20] = '{S32_MAX, S32_MIN, S32_MAX, 0, S32_MIN, 0, -1, S32_MIN,
                         0, 1, 5, -1, S32_MAX, 0, S32_MAX, S32_MAX - 1, 1000,
                         S32_MAX, S32_MIN + 1, 12344};
    for (int i = 0; i < 20; i++)
      send_request(lo_list[i], hi_list[i]);
  endtask

  // Mostly well-formed ranges of every width, plus inverted pairs, corners
  // and the full range.
  task automatic run_random(input int count);
    int lo;
    int hi;
    int a;
    int b;
    int span;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          lo   = $urandom;
          span = $urandom >> $urandom_range(1, 31);
          hi   = (lo > S32_MAX - span) ? S32_MAX : lo + span;
        end
        6: begin
          lo = $urandom;
          hi = $urandom;
        end
        7: begin
          a = $urandom;
          b = $urandom;
          if (a == b) b = b ^ 1;
          lo = (a > b) ? a : b;
          hi = (a > b) ? b : a;
        end
        8: begin
          lo = corner_value($urandom_range(0, 3));
          hi = corner_value($urandom_range(0, 3));
        end
        default: begin
          lo = S32_MIN;
          hi = S32_MAX;
        end
      endcase
      send_request(lo, hi);
    end
  endtask

  // Receiver: random stall bursts, none in quiet stretches, and one long
  // hold-off per request from the stimulus, counted here in cycles.
  initial begin
    int unsigned hold_seen;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_tready <= 1'b1;
      end else if (rst_n && !quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end a hung run.
  initial begin
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // seed from reset (zero), then the same corners with a seed that wraps the sum
    run_directed();
    program_seed(64'hFFFF_FFFF_FFFF_FFFF);
    hold_reqs++;  // stall the result side while requests keep coming
    run_directed();
    run_random(100);

    program_seed(64'h0);
    run_random(150);
    program_seed(64'h8000_0000_0000_0000);
    run_random(150);

    for (int p = 0; p < 4; p++) begin
      program_seed({$urandom, $urandom});
      quiet = (p == 2);
      run_random(150);
    end

    // final stretch runs without idling on either side
    program_seed({$urandom, $urandom});
    quiet = 1'b1;
    run_random(200);

    drain_results(TAIL_WAIT);

    $display("Covered %0d requests (%0d with inverted bounds) over %0d seed writes",
             sent, inverted, seed_writes);
    $display("Compared %0d results field by field", checked);
    if (mismatches == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
